// ===== rtl/core/efr_pkg.sv =====
// Package for the escaped frame receiver: status codes, framing byte codes,
// the result record and fixed constants. No dependencies.
`default_nettype none

package efr_pkg;

    // Width of the minimum frame length register.
    localparam int CFG_W = 10;

    // Reset value of the minimum frame length register.
    localparam logic [CFG_W-1:0] MIN_LEN_RESET = 10'd10;

    // Bytes of framing overhead subtracted from the count before the length check.
    localparam int LEN_OVERHEAD = 10;

    // Framing byte codes.
    localparam logic [7:0] FRAME_DELIM = 8'h00;
    localparam logic [7:0] ESC_MARK    = 8'h01;
    localparam logic [7:0] ESC_ZERO    = 8'h02;
    localparam logic [7:0] ESC_ONE     = 8'h03;

    // Frame verdict codes.
    typedef enum logic [2:0] {
        STATUS_OK           = 3'd0,
        STATUS_OUT_OF_ORDER = 3'd1,
        STATUS_BAD_LENGTH   = 3'd2,
        STATUS_BAD_CHECKSUM = 3'd3,
        STATUS_TOO_SHORT    = 3'd4,
        STATUS_ESCAPE_ERROR = 3'd5,
        STATUS_OVERFLOW     = 3'd6
    } status_t;

    // One result transaction: a payload byte or a frame verdict.
    typedef struct packed {
        logic       valid;
        logic       is_frame_end;
        logic [7:0] payload_byte;
        status_t    frame_status;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/escaped_frame_receiver.sv =====
// Escaped frame receiver top level: input register, deframer and result register.
// Depends on efr_pkg and instantiates efr_deframer.
//
// Usage: raw link bytes enter on rx_byte with byte_valid; a transaction is
// taken at a rising edge with byte_valid high and byte_stall low. Results
// leave on is_frame_end, payload_byte and frame_status with result_valid and
// are taken when result_stall is low. Each payload byte is released when the
// following byte of the frame arrives, so the checksum byte is never sent; a
// frame end or an escape error gives one verdict transaction.
// A byte taken into the input register passes through the combinational
// deframer step and its result is captured in the result register.
// Throughput is one byte per cycle unless result_stall holds a waiting
// result; then the input register keeps its byte and byte_stall rises in
// the same cycle.
// min_frame_length is written through cfg_write_en / cfg_write_data.
// Reset clears all framing state, sets min_frame_length to 10 and empties
// both registers.
`default_nettype none

module escaped_frame_receiver
    import efr_pkg::*;
#(
    parameter int MAX_FRAME = 512
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write_en,
    input  wire logic [CFG_W-1:0] cfg_write_data,
    input  wire logic             byte_valid,
    output logic                  byte_stall,
    input  wire logic [7:0]       rx_byte,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output logic                  is_frame_end,
    output logic [7:0]            payload_byte,
    output logic [2:0]            frame_status
);

    logic [CFG_W-1:0] min_len_reg;
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             out_valid_reg;
    logic             out_end_reg;
    logic [7:0]       out_byte_reg;
    status_t          out_status_reg;
    logic             advance;
    result_t          result;

    // The held byte moves on when the result register is free or draining.
    assign advance    = in_valid_reg && (!out_valid_reg || !result_stall);
    assign byte_stall = in_valid_reg && !advance;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= MIN_LEN_RESET;
        end
        else if (cfg_write_en)
        begin
            min_len_reg <= cfg_write_data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    // Framing state and per-byte decode.
    efr_deframer #(
        .MAX_FRAME (MAX_FRAME)
    ) u_deframer (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .rx_byte          (in_byte_reg),
        .min_frame_length (min_len_reg),
        .result           (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (result.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            out_end_reg    <= result.is_frame_end;
            out_byte_reg   <= result.payload_byte;
            out_status_reg <= result.frame_status;
        end
    end

    assign result_valid = out_valid_reg;
    assign is_frame_end = out_end_reg;
    assign payload_byte = out_byte_reg;
    assign frame_status = out_status_reg;

endmodule

`default_nettype wire

// ===== rtl/core/efr_frame_check.sv =====
// Frame-end verdict logic for the escaped frame receiver.
// Depends on efr_pkg for the status codes and constants.
`default_nettype none

module efr_frame_check
    import efr_pkg::*;
#(
    parameter int CW = 10
)(
    input  wire logic             overflowed,
    input  wire logic [CW-1:0]    byte_count,
    input  wire logic [CFG_W-1:0] min_frame_length,
    input  wire logic [31:0]      length_field,
    input  wire logic [31:0]      sequence_field,
    input  wire logic [31:0]      last_sequence_id,
    input  wire logic [7:0]       running_xor,
    output status_t               status
);

    localparam int CMPW = (CW > CFG_W) ? CW : CFG_W;

    logic [CMPW-1:0]   count_ext;
    logic [CMPW-1:0]   min_ext;
    logic              too_short;
    logic              out_of_order;
    logic signed [32:0] count_minus;
    logic signed [32:0] length_ext;
    logic              bad_length;

    // Widen both sides of the length compare to a common width.
    assign count_ext = CMPW'(byte_count);
    assign min_ext   = CMPW'(min_frame_length);
    assign too_short = count_ext < min_ext;

    // A positive (signed) id must be strictly newer than the last accepted one.
    assign out_of_order = ($signed(sequence_field) > 32'sd0) &&
                          ($signed(sequence_field) <= $signed(last_sequence_id));

    // Compare the byte count less the overhead with the signed length field.
    assign count_minus = $signed({{(33-CW){1'b0}}, byte_count}) - 33'(LEN_OVERHEAD);
    assign length_ext  = $signed({length_field[31], length_field});
    assign bad_length  = count_minus != length_ext;

    // Checks are applied in priority order.
    always_comb
    begin
        if (overflowed)
        begin
            status = STATUS_OVERFLOW;
        end
        else if (too_short)
        begin
            status = STATUS_TOO_SHORT;
        end
        else if (out_of_order)
        begin
            status = STATUS_OUT_OF_ORDER;
        end
        else if (bad_length)
        begin
            status = STATUS_BAD_LENGTH;
        end
        else if (running_xor != 8'h00)
        begin
            status = STATUS_BAD_CHECKSUM;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/efr_deframer.sv =====
// Framing state and per-byte processing for the escaped frame receiver.
// Depends on efr_pkg and instantiates efr_frame_check.
`default_nettype none

module efr_deframer
    import efr_pkg::*;
#(
    parameter int MAX_FRAME = 512
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic [7:0]       rx_byte,
    input  wire logic [CFG_W-1:0] min_frame_length,
    output result_t               result
);

    localparam int CW = $clog2(MAX_FRAME + 1);

    logic [CW-1:0] byte_count_reg,       byte_count_next;
    logic          prev_zero_seen_reg,   prev_zero_seen_next;
    logic          in_frame_reg,         in_frame_next;
    logic          escape_pending_reg,   escape_pending_next;
    logic [31:0]   last_sequence_id_reg, last_sequence_id_next;
    logic [7:0]    running_xor_reg,      running_xor_next;
    logic [31:0]   length_field_reg,     length_field_next;
    logic [31:0]   sequence_field_reg,   sequence_field_next;
    logic [7:0]    held_byte_reg,        held_byte_next;
    logic          overflowed_reg,       overflowed_next;

    status_t       verdict;
    logic [7:0]    decoded;
    logic          escape_error;

    // Verdict for the frame currently held in the state.
    efr_frame_check #(
        .CW (CW)
    ) u_check (
        .overflowed       (overflowed_reg),
        .byte_count       (byte_count_reg),
        .min_frame_length (min_frame_length),
        .length_field     (length_field_reg),
        .sequence_field   (sequence_field_reg),
        .last_sequence_id (last_sequence_id_reg),
        .running_xor      (running_xor_reg),
        .status           (verdict)
    );

    // Undo the escape on the incoming byte.
    always_comb
    begin
        decoded      = rx_byte;
        escape_error = 1'b0;
        if (escape_pending_reg)
        begin
            case (rx_byte)
                ESC_ZERO: decoded = 8'h00;
                ESC_ONE:  decoded = 8'h01;
                default:  escape_error = 1'b1;
            endcase
        end
    end

    // Next state and result for one byte.
    always_comb
    begin
        byte_count_next       = byte_count_reg;
        prev_zero_seen_next   = prev_zero_seen_reg;
        in_frame_next         = in_frame_reg;
        escape_pending_next   = escape_pending_reg;
        last_sequence_id_next = last_sequence_id_reg;
        running_xor_next      = running_xor_reg;
        length_field_next     = length_field_reg;
        sequence_field_next   = sequence_field_reg;
        held_byte_next        = held_byte_reg;
        overflowed_next       = overflowed_reg;

        result.valid        = 1'b0;
        result.is_frame_end = 1'b0;
        result.payload_byte = 8'h00;
        result.frame_status = STATUS_OK;

        if (step)
        begin
            if (rx_byte == FRAME_DELIM)
            begin
                // A delimiter closes any open frame with a verdict.
                if (in_frame_reg)
                begin
                    result.valid        = 1'b1;
                    result.is_frame_end = 1'b1;
                    result.frame_status = verdict;
                    if (verdict == STATUS_OK)
                    begin
                        last_sequence_id_next = sequence_field_reg;
                    end
                end
                byte_count_next     = '0;
                running_xor_next    = 8'h00;
                length_field_next   = '0;
                sequence_field_next = '0;
                held_byte_next      = 8'h00;
                overflowed_next     = 1'b0;
                in_frame_next       = prev_zero_seen_reg;
                prev_zero_seen_next = 1'b1;
            end
            else if (in_frame_reg)
            begin
                prev_zero_seen_next = 1'b0;
                if (rx_byte == ESC_MARK)
                begin
                    escape_pending_next = 1'b1;
                end
                else
                begin
                    escape_pending_next = 1'b0;
                    if (escape_error)
                    begin
                        // Abort the frame and wait for a fresh opening pair.
                        byte_count_next     = '0;
                        running_xor_next    = 8'h00;
                        length_field_next   = '0;
                        sequence_field_next = '0;
                        held_byte_next      = 8'h00;
                        overflowed_next     = 1'b0;
                        in_frame_next       = 1'b0;
                        result.valid        = 1'b1;
                        result.is_frame_end = 1'b1;
                        result.frame_status = STATUS_ESCAPE_ERROR;
                    end
                    else if (byte_count_reg >= CW'(MAX_FRAME))
                    begin
                        overflowed_next = 1'b1;
                    end
                    else
                    begin
                        // Capture the little-endian header fields.
                        for (int i = 0; i < 4; i++)
                        begin
                            if (byte_count_reg == CW'(i + 1))
                            begin
                                length_field_next[8*i +: 8] =
                                    length_field_reg[8*i +: 8] | decoded;
                            end
                            if (byte_count_reg == CW'(i + 5))
                            begin
                                sequence_field_next[8*i +: 8] =
                                    sequence_field_reg[8*i +: 8] | decoded;
                            end
                        end
                        running_xor_next = running_xor_reg ^ decoded;
                        // The byte held from the last step goes out now.
                        if (byte_count_reg != '0)
                        begin
                            result.valid        = 1'b1;
                            result.payload_byte = held_byte_reg;
                        end
                        held_byte_next  = decoded;
                        byte_count_next = byte_count_reg + 1'b1;
                    end
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg       <= '0;
            prev_zero_seen_reg   <= 1'b0;
            in_frame_reg         <= 1'b0;
            escape_pending_reg   <= 1'b0;
            last_sequence_id_reg <= '0;
            running_xor_reg      <= 8'h00;
            length_field_reg     <= '0;
            sequence_field_reg   <= '0;
            held_byte_reg        <= 8'h00;
            overflowed_reg       <= 1'b0;
        end
        else
        begin
            byte_count_reg       <= byte_count_next;
            prev_zero_seen_reg   <= prev_zero_seen_next;
            in_frame_reg         <= in_frame_next;
            escape_pending_reg   <= escape_pending_next;
            last_sequence_id_reg <= last_sequence_id_next;
            running_xor_reg      <= running_xor_next;
            length_field_reg     <= length_field_next;
            sequence_field_reg   <= sequence_field_next;
            held_byte_reg        <= held_byte_next;
            overflowed_reg       <= overflowed_next;
        end
    end

endmodule

`default_nettype wire
